@@ src/csl_pkg.sv @@
// ---------------------------------------------------------------------------
// csl_pkg
// Shared types, widths, character codes and the byte classifier for the
// character stream lexer.
// ---------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

    // field widths
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 16;
    localparam int KIND_BITS   = 3;

    // token queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

    // stream payload packing
    localparam int IN_TDATA_BITS   = 8;
    localparam int OUT_FIELD_BITS  = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS    = OUT_TDATA_BITS - OUT_FIELD_BITS;

    // special characters
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        KIND_NUMBER  = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_KEYWORD = 3'd2,
        KIND_ASSIGN  = 3'd3,
        KIND_STRING  = 3'd4,
        KIND_OPER    = 3'd5,
        KIND_SEP     = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        MODE_NUM    = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_KEY    = 3'd2,
        MODE_ASSIGN = 3'd3,
        MODE_STR    = 3'd4,
        MODE_IDLE   = 3'd5,
        MODE_ERR    = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        CLS_OP,
        CLS_SEP,
        CLS_DIGIT,
        CLS_ALPHA,
        CLS_COLON,
        CLS_EQ,
        CLS_SPECIAL,
        CLS_QUOTE,
        CLS_BAD
    } t_cls;

    typedef struct packed {
        t_kind                  kind;
        logic                   is_error;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] len;
        logic [LINE_BITS-1:0]   line;
    } t_result;

    // one queue entry: the one or two tokens a single byte produced
    typedef struct packed {
        logic    two;
        t_result res_a;
        t_result res_b;
    } t_qrec;

    function automatic logic csl_is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
    endfunction

    function automatic t_cls csl_classify(input logic [7:0] c);
        t_cls k;
        if (csl_is_space(c) || c == 8'h3B || c == 8'h2C || c == 8'h7B || c == 8'h7D ||
            c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D) begin
            k = CLS_SEP;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            k = CLS_DIGIT;
        end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
            k = CLS_ALPHA;
        end else if (c == CH_DOLLAR || c == CH_AT || c == CH_QMARK) begin
            k = CLS_SPECIAL;
        end else if (c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
                     c == CH_PERCENT || c == 8'h3C || c == 8'h3E) begin
            k = CLS_OP;
        end else if (c == CH_EQUALS) begin
            k = CLS_EQ;
        end else if (c == CH_COLON) begin
            k = CLS_COLON;
        end else if (c == CH_QUOTE) begin
            k = CLS_QUOTE;
        end else begin
            k = CLS_BAD;
        end
        return k;
    endfunction

    function automatic t_result csl_make_res(
        input t_kind                  kind,
        input logic                   is_error,
        input logic [OFFSET_BITS-1:0] start,
        input logic [LENGTH_BITS-1:0] len,
        input logic [LINE_BITS-1:0]   line
    );
        t_result r;
        r.kind     = kind;
        r.is_error = is_error;
        r.start    = start;
        r.len      = len;
        r.line     = line;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/csl_front.sv @@
// ---------------------------------------------------------------------------
// csl_front
// Accepts one byte per beat, classifies it, advances the token state and
// pushes the tokens it produces (zero, one or two) into the token queue.
// ---------------------------------------------------------------------------
`default_nettype none

module csl_front
    import csl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    output logic            o_ready,
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_qrec           o_q_rec
);

    t_mode                  r_mode,       n_mode;
    logic                   r_pend_valid, n_pend_valid;
    logic [7:0]             r_pend_char,  n_pend_char;
    logic [OFFSET_BITS-1:0] r_tok_start,  n_tok_start;
    logic [LENGTH_BITS-1:0] r_tok_len,    n_tok_len;
    logic [LINE_BITS-1:0]   r_cur_line,   n_cur_line;
    logic [OFFSET_BITS-1:0] r_byte_pos,   n_byte_pos;

    logic                   w_accept;
    t_cls                   w_cls;
    t_cls                   w_pcls;
    t_result                w_res [2];
    logic [1:0]             w_cnt;
    logic                   w_err;
    logic                   w_delim;
    logic                   w_cont;
    logic                   w_skip;
    t_kind                  w_mode_kind;
    logic [LENGTH_BITS-1:0] w_len_inc;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_cls    = csl_classify(i_byte);
    assign w_pcls   = csl_classify(r_pend_char);

    // saturating length step
    assign w_len_inc = (r_tok_len == {LENGTH_BITS{1'b1}}) ? r_tok_len
                                                          : r_tok_len + LENGTH_BITS'(1);

    assign w_mode_kind = (r_mode == MODE_NUM)   ? KIND_NUMBER :
                         (r_mode == MODE_IDENT) ? KIND_IDENT  : KIND_KEYWORD;

    // next state and token emission
    always_comb begin
        n_mode       = r_mode;
        n_pend_valid = r_pend_valid;
        n_pend_char  = r_pend_char;
        n_tok_start  = r_tok_start;
        n_tok_len    = r_tok_len;
        n_cur_line   = r_cur_line;
        n_byte_pos   = r_byte_pos;
        w_res[0]     = '0;
        w_res[1]     = '0;
        w_cnt        = 2'd0;
        w_err        = 1'b0;
        w_skip       = 1'b0;
        w_delim      = (w_cls == CLS_OP) || (w_cls == CLS_EQ) || (w_cls == CLS_SEP) ||
                       ((r_mode == MODE_IDENT) && (w_cls == CLS_COLON));
        w_cont       = ((w_cls == CLS_DIGIT) && (r_mode != MODE_KEY)) ||
                       ((w_cls == CLS_ALPHA) && (r_mode != MODE_NUM));

        if (w_accept && r_mode != MODE_ERR) begin
            unique case (r_mode)
                MODE_NUM, MODE_IDENT, MODE_KEY: begin
                    if (w_delim) begin
                        w_res[w_cnt[0]] = csl_make_res(w_mode_kind, 1'b0, r_tok_start,
                                                       r_tok_len, r_cur_line);
                        w_cnt = w_cnt + 2'd1;
                        if (!csl_is_space(i_byte)) begin
                            n_pend_valid = 1'b1;
                            n_pend_char  = i_byte;
                            n_tok_start  = r_byte_pos;
                            n_tok_len    = LENGTH_BITS'(1);
                        end
                        n_mode = MODE_IDLE;
                    end else if (w_cont) begin
                        n_tok_len = w_len_inc;
                    end else begin
                        w_err = 1'b1;
                    end
                end
                MODE_ASSIGN: begin
                    if (w_cls == CLS_EQ) begin
                        w_res[w_cnt[0]] = csl_make_res(KIND_ASSIGN, 1'b0, r_tok_start,
                                                       LENGTH_BITS'(2), r_cur_line);
                        w_cnt  = w_cnt + 2'd1;
                        n_mode = MODE_IDLE;
                    end else begin
                        w_err = 1'b1;
                    end
                end
                MODE_STR: begin
                    n_tok_len = w_len_inc;
                    if (w_cls == CLS_QUOTE) begin
                        w_res[w_cnt[0]] = csl_make_res(KIND_STRING, 1'b0, r_tok_start,
                                                       w_len_inc, r_cur_line);
                        w_cnt  = w_cnt + 2'd1;
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_IDLE: begin
                    // held-over one-character token goes first
                    if (r_pend_valid) begin
                        n_pend_valid = 1'b0;
                        if (w_pcls == CLS_COLON) begin
                            w_skip = 1'b1;
                            if (w_cls == CLS_EQ) begin
                                w_res[w_cnt[0]] = csl_make_res(KIND_ASSIGN, 1'b0, r_tok_start,
                                                               LENGTH_BITS'(2), r_cur_line);
                                w_cnt = w_cnt + 2'd1;
                            end else begin
                                w_err = 1'b1;
                            end
                        end else begin
                            w_res[w_cnt[0]] = csl_make_res(
                                (w_pcls == CLS_SEP) ? KIND_SEP : KIND_OPER, 1'b0,
                                r_tok_start, LENGTH_BITS'(1), r_cur_line);
                            w_cnt = w_cnt + 2'd1;
                        end
                    end
                    if (!w_skip) begin
                        unique case (w_cls)
                            CLS_OP, CLS_EQ: begin
                                w_res[w_cnt[0]] = csl_make_res(KIND_OPER, 1'b0, r_byte_pos,
                                                               LENGTH_BITS'(1), r_cur_line);
                                w_cnt = w_cnt + 2'd1;
                            end
                            CLS_QUOTE: begin
                                n_mode      = MODE_STR;
                                n_tok_start = r_byte_pos;
                                n_tok_len   = LENGTH_BITS'(1);
                            end
                            CLS_ALPHA: begin
                                n_mode      = MODE_KEY;
                                n_tok_start = r_byte_pos;
                                n_tok_len   = LENGTH_BITS'(1);
                            end
                            CLS_DIGIT: begin
                                n_mode      = MODE_NUM;
                                n_tok_start = r_byte_pos;
                                n_tok_len   = LENGTH_BITS'(1);
                            end
                            CLS_SPECIAL: begin
                                n_mode      = MODE_IDENT;
                                n_tok_start = r_byte_pos;
                                n_tok_len   = LENGTH_BITS'(1);
                            end
                            CLS_COLON: begin
                                n_mode      = MODE_ASSIGN;
                                n_tok_start = r_byte_pos;
                                n_tok_len   = LENGTH_BITS'(1);
                            end
                            CLS_SEP: begin
                                if (!csl_is_space(i_byte)) begin
                                    w_res[w_cnt[0]] = csl_make_res(KIND_SEP, 1'b0, r_byte_pos,
                                                                   LENGTH_BITS'(1), r_cur_line);
                                    w_cnt = w_cnt + 2'd1;
                                end
                            end
                            default: begin
                                w_err = 1'b1;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase

            // error result follows any held-over token
            if (w_err) begin
                w_res[w_cnt[0]] = csl_make_res(KIND_NUMBER, 1'b1, r_byte_pos,
                                               LENGTH_BITS'(1), r_cur_line);
                w_cnt        = w_cnt + 2'd1;
                n_mode       = MODE_ERR;
                n_pend_valid = 1'b0;
            end

            // line advances after this byte's tokens
            if (i_byte == CH_NEWLINE && r_cur_line != {LINE_BITS{1'b1}}) begin
                n_cur_line = r_cur_line + LINE_BITS'(1);
            end
            n_byte_pos = r_byte_pos + OFFSET_BITS'(1);
        end
    end

    assign o_q_push      = w_accept && (w_cnt != 2'd0);
    assign o_q_rec.two   = w_cnt[1];
    assign o_q_rec.res_a = w_res[0];
    assign o_q_rec.res_b = w_res[1];

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_pend_valid <= 1'b0;
            r_pend_char  <= '0;
            r_tok_start  <= '0;
            r_tok_len    <= '0;
            r_cur_line   <= LINE_BITS'(1);
            r_byte_pos   <= '0;
        end else begin
            r_mode       <= n_mode;
            r_pend_valid <= n_pend_valid;
            r_pend_char  <= n_pend_char;
            r_tok_start  <= n_tok_start;
            r_tok_len    <= n_tok_len;
            r_cur_line   <= n_cur_line;
            r_byte_pos   <= n_byte_pos;
        end
    end

endmodule

`default_nettype wire

@@ src/csl_queue.sv @@
// ---------------------------------------------------------------------------
// csl_queue
// Small register queue of token records between the classifier front and
// the output back end.
// ---------------------------------------------------------------------------
`default_nettype none

module csl_queue
    import csl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qrec i_rec,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_qrec      o_head
);

    t_qrec                     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count,  n_count;
    logic                      w_do_push;
    logic                      w_do_pop;

    assign o_full    = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointer and fill count
    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + QUEUE_PTR_BITS'(1) : r_wr_ptr;
        n_rd_ptr = w_do_pop  ? r_rd_ptr + QUEUE_PTR_BITS'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + QUEUE_CNT_BITS'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

@@ src/csl_back.sv @@
// ---------------------------------------------------------------------------
// csl_back
// Unpacks each queued record into one or two output beats and marks the
// final token that a byte produced.
// ---------------------------------------------------------------------------
`default_nettype none

module csl_back
    import csl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_qrec i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_result,
    output logic       o_last
);

    logic r_sel, n_sel;
    logic w_beat;

    assign o_valid  = !i_empty;
    assign o_result = r_sel ? i_head.res_b : i_head.res_a;
    assign o_last   = r_sel || !i_head.two;
    assign w_beat   = o_valid && i_ready;
    assign o_pop    = w_beat && o_last;

    // second-token select
    always_comb begin
        n_sel = r_sel;
        if (w_beat) begin
            n_sel = !o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= n_sel;
        end
    end

endmodule

`default_nettype wire

@@ src/char_stream_lexer_core.sv @@
// ---------------------------------------------------------------------------
// char_stream_lexer_core
// Byte stream lexer: numbers, identifiers, keywords, assignments, strings,
// operators and separators, each reported with offset, length and line.
// ---------------------------------------------------------------------------
// The lexer takes one source byte per beat on the slave side, one per clock
// as long as its four-entry token queue has room, and the byte is classified
// and folded into the token state in that same cycle. A byte yields zero,
// one or two tokens; they leave on the master side one per beat, tlast set
// on the last token of a byte, so sustained throughput is one byte per clock
// while tokens average at most one per clock, and otherwise the output side
// (one token per cycle) sets the pace. A byte's tokens are registered in the
// token queue on their way out. An illegal byte emits a single token with
// tuser set and the lexer then drops all bytes until reset.
`default_nettype none

module char_stream_lexer_core
    import csl_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] in_byte
    input  wire logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // [2:0] token_kind, [34:3] start_offset, [50:35] token_len,
    // [66:51] line_number, rest zero
    output logic [OUT_TDATA_BITS-1:0]      o_m_axis_tdata,
    // [0] is_error
    output logic                           o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);

    logic    w_q_full;
    logic    w_q_push;
    t_qrec   w_q_rec;
    logic    w_q_pop;
    logic    w_q_empty;
    t_qrec   w_q_head;
    t_result w_result;

    // classifier and token state
    csl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_byte   (i_s_axis_tdata),
        .o_ready  (o_s_axis_tready),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_rec  (w_q_rec)
    );

    // token queue
    csl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_rec   (w_q_rec),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    // output serializer
    csl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_q_empty),
        .i_head   (w_q_head),
        .o_pop    (w_q_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result),
        .o_last   (o_m_axis_tlast)
    );

    // output beat packing
    assign o_m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, w_result.line, w_result.len,
                             w_result.start, w_result.kind};
    assign o_m_axis_tuser = w_result.is_error;

endmodule

`default_nettype wire

@@ tb/char_stream_lexer_core_tb.sv @@
// ---------------------------------------------------------------------------
// char_stream_lexer_core_tb
// Self-checking bench for the byte stream lexer. Source bytes are pushed
// through the slave stream and every token on the master stream is checked
// against an in-bench lexer model: a short directed text, a string with
// arbitrary bytes and a short run of newlines, random well-formed token
// streams under several idle/stall mixes with one long output hold-off,
// and one sticky error case at the end.
// ---------------------------------------------------------------------------
`default_nettype none

module char_stream_lexer_core_tb import csl_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 500;

    typedef enum logic [3:0] {
        BC_OP, BC_SEP, BC_DIGIT, BC_ALPHA, BC_COLON, BC_EQ, BC_SIGIL, BC_QUOTE, BC_BAD
    } t_byte_class;

    typedef enum logic [2:0] {
        LX_NUM, LX_IDENT, LX_KEY, LX_ASSIGN, LX_STR, LX_IDLE, LX_ERR
    } t_lex_mode;

    typedef struct packed {
        t_kind                   kind;
        logic                    is_error;
        logic [OFFSET_BITS-1:0]  start;
        logic [LENGTH_BITS-1:0]  len;
        logic [LINE_BITS-1:0]    line;
        logic                    last;
        logic [OUT_PAD_BITS-1:0] pad;
    } t_token_rec;

    // lexer model plus the queue of tokens still owed by the block
    class lex_scoreboard;
        t_lex_mode              mode;
        logic                   pend_valid;
        logic [7:0]             pend_char;
        logic [OFFSET_BITS-1:0] tok_start;
        logic [OFFSET_BITS-1:0] byte_pos;
        logic [LENGTH_BITS-1:0] tok_len;
        logic [LINE_BITS-1:0]   cur_line;
        t_token_rec             owed_tokens[$];
        t_token_rec             byte_tokens[$];
        int                     mismatches;

        function new();
            mode       = LX_IDLE;
            pend_valid = 1'b0;
            pend_char  = '0;
            tok_start  = '0;
            tok_len    = '0;
            cur_line   = 1;
            byte_pos   = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed_tokens.size();
        endfunction

        function logic is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;
        endfunction

        function t_byte_class class_of(logic [7:0] c);
            if (is_blank(c)) return BC_SEP;
            case (c)
                ";", ",", "{", "}", "(", ")", "[", "]": return BC_SEP;
                "+", "-", "*", "/", "<", ">", CH_PERCENT: return BC_OP;
                CH_DOLLAR, CH_AT, CH_QMARK: return BC_SIGIL;
                CH_EQUALS: return BC_EQ;
                CH_COLON: return BC_COLON;
                CH_QUOTE: return BC_QUOTE;
                default: ;
            endcase
            if (c >= "0" && c <= "9") return BC_DIGIT;
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return BC_ALPHA;
            return BC_BAD;
        endfunction

        function void add_token(t_kind kind, logic is_err, logic [OFFSET_BITS-1:0] start,
                                logic [LENGTH_BITS-1:0] len);
            t_token_rec t;
            t.kind     = kind;
            t.is_error = is_err;
            t.start    = start;
            t.len      = len;
            t.line     = cur_line;
            t.last     = 1'b0;
            t.pad      = '0;
            byte_tokens.push_back(t);
        endfunction

        function t_kind word_kind(t_lex_mode m);
            case (m)
                LX_NUM:   return KIND_NUMBER;
                LX_IDENT: return KIND_IDENT;
                default:  return KIND_KEYWORD;
            endcase
        endfunction

        function void open_token(t_lex_mode m, logic [OFFSET_BITS-1:0] pos);
            mode      = m;
            tok_start = pos;
            tok_len   = 1;
        endfunction

        // fold one accepted byte into the model and queue the tokens it yields
        function void note_byte(logic [7:0] c);
            t_byte_class            k;
            t_byte_class            pk;
            logic [OFFSET_BITS-1:0] pos;
            logic                   err;
            logic                   delim;
            logic                   cont;
            logic                   done;
            pos = byte_pos;
            err = 1'b0;
            done = 1'b0;
            byte_tokens.delete();
            if (mode == LX_ERR) return;
            k = class_of(c);

            case (mode)
                LX_NUM, LX_IDENT, LX_KEY: begin
                    delim = k == BC_OP || k == BC_EQ || k == BC_SEP ||
                            (mode == LX_IDENT && k == BC_COLON);
                    cont  = (k == BC_DIGIT && mode != LX_KEY) ||
                            (k == BC_ALPHA && mode != LX_NUM);
                    if (delim) begin
                        add_token(word_kind(mode), 1'b0, tok_start, tok_len);
                        // a visible delimiter comes out with the next byte
                        if (!is_blank(c)) begin
                            pend_valid = 1'b1;
                            pend_char  = c;
                            tok_start  = pos;
                            tok_len    = 1;
                        end
                        mode = LX_IDLE;
                    end else if (cont) begin
                        if (tok_len != '1) tok_len = tok_len + 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                LX_ASSIGN: begin
                    if (k == BC_EQ) begin
                        add_token(KIND_ASSIGN, 1'b0, tok_start, 2);
                        mode = LX_IDLE;
                    end else begin
                        err = 1'b1;
                    end
                end
                LX_STR: begin
                    if (tok_len != '1) tok_len = tok_len + 1'b1;
                    if (k == BC_QUOTE) begin
                        add_token(KIND_STRING, 1'b0, tok_start, tok_len);
                        mode = LX_IDLE;
                    end
                end
                default: begin
                    // held-over delimiter first; a held colon needs '='
                    if (pend_valid) begin
                        pk = class_of(pend_char);
                        pend_valid = 1'b0;
                        if (pk == BC_COLON) begin
                            if (k == BC_EQ) add_token(KIND_ASSIGN, 1'b0, tok_start, 2);
                            else err = 1'b1;
                            done = 1'b1;
                        end else begin
                            add_token(pk == BC_SEP ? KIND_SEP : KIND_OPER, 1'b0, tok_start, 1);
                        end
                    end
                    if (!done) begin
                        case (k)
                            BC_OP, BC_EQ: add_token(KIND_OPER, 1'b0, pos, 1);
                            BC_QUOTE:     open_token(LX_STR, pos);
                            BC_ALPHA:     open_token(LX_KEY, pos);
                            BC_DIGIT:     open_token(LX_NUM, pos);
                            BC_SIGIL:     open_token(LX_IDENT, pos);
                            BC_COLON:     open_token(LX_ASSIGN, pos);
                            BC_SEP: begin
                                if (!is_blank(c)) add_token(KIND_SEP, 1'b0, pos, 1);
                            end
                            default:      err = 1'b1;
                        endcase
                    end
                end
            endcase

            if (err) begin
                add_token(KIND_NUMBER, 1'b1, pos, 1);
                mode       = LX_ERR;
                pend_valid = 1'b0;
            end
            if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
            foreach (byte_tokens[i]) owed_tokens.push_back(byte_tokens[i]);
            // line moves on only after this byte's tokens took the old value
            if (c == CH_NEWLINE && cur_line != '1) cur_line = cur_line + 1'b1;
            byte_pos = pos + 1'b1;
        endfunction

        function void check_token(t_token_rec got);
            t_token_rec exp;
            if (owed_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected token kind=%0d err=%0b start=%0d %s",
                             got.kind, got.is_error, got.start,
                             $sformatf("len=%0d line=%0d", got.len, got.line));
                return;
            end
            exp = owed_tokens.pop_front();
            if (got.kind !== exp.kind || got.is_error !== exp.is_error ||
                got.start !== exp.start || got.len !== exp.len || got.line !== exp.line ||
                got.last !== exp.last || got.pad !== exp.pad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp kind=%0d err=%0b start=%0d len=%0d line=%0d %s",
                             exp.kind, exp.is_error, exp.start, exp.len, exp.line,
                             $sformatf("last=%0b pad=%h", exp.last, exp.pad));
                    $display("          got kind=%0d err=%0b start=%0d len=%0d line=%0d %s",
                             got.kind, got.is_error, got.start, got.len, got.line,
                             $sformatf("last=%0b pad=%h", got.last, got.pad));
                end
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata = '0;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;
    logic                      o_m_axis_tuser;
    logic                      o_m_axis_tlast;

    lex_scoreboard sb;
    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    int  bytes_sent = 0;
    int  cycle_count = 0;
    logic hold_go = 1'b0;
    logic hold_sink = 1'b0;

    char_stream_lexer_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver ready, random stalls unless held off
    always @(posedge i_clk) begin
        i_m_axis_tready <= hold_sink ? 1'b0 : ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // one long output hold-off so the token queue fills and input backs up
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_sink <= 1'b0;
    end

    // beat monitor: predict on accepted bytes, then check accepted tokens
    always @(posedge i_clk) begin
        t_token_rec got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) sb.note_byte(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind     = t_kind'(o_m_axis_tdata[KIND_BITS-1:0]);
                got.is_error = o_m_axis_tuser;
                got.start    = o_m_axis_tdata[KIND_BITS +: OFFSET_BITS];
                got.len      = o_m_axis_tdata[KIND_BITS+OFFSET_BITS +: LENGTH_BITS];
                got.line     = o_m_axis_tdata[KIND_BITS+OFFSET_BITS+LENGTH_BITS +: LINE_BITS];
                got.last     = o_m_axis_tlast;
                got.pad      = o_m_axis_tdata[OUT_TDATA_BITS-1 -: OUT_PAD_BITS];
                sb.check_token(got);
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_char(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25))
                                    : 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_string_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
        return b;
    endfunction

    // word terminator; an identifier may also end in a ':=' pair
    task automatic send_delim(input logic ident);
        int r;
        r = $urandom_range(0, 9);
        if (ident && r == 0) send_text(":=");
        else if (r < 4) put_byte(pick_char("+-*/%<>="));
        else put_byte(pick_char(";,{}()[] \t\n"));
    endtask

    // one well-formed token with random content
    task automatic send_random_token();
        int n;
        case ($urandom_range(0, 9))
            0, 1: begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                repeat (n) put_byte(rand_digit());
                send_delim(1'b0);
            end
            2, 3: begin
                repeat ($urandom_range(1, 8)) put_byte(rand_letter());
                send_delim(1'b0);
            end
            4: begin
                put_byte(pick_char("$@?"));
                repeat ($urandom_range(0, 6))
                    put_byte($urandom_range(0, 1) ? rand_letter() : rand_digit());
                send_delim(1'b1);
            end
            5: begin
                put_byte(CH_QUOTE);
                repeat ($urandom_range(0, 10)) put_byte(rand_string_byte());
                put_byte(CH_QUOTE);
            end
            6: send_text(":=");
            7: put_byte(pick_char("+-*/%<>="));
            8: put_byte(pick_char(";,{}()[]"));
            default: begin
                repeat ($urandom_range(1, 4)) put_byte(pick_char(" \t\n;,()+=<"));
            end
        endcase
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input int nbytes);
        int target;
        target = bytes_sent + nbytes;
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
        while (bytes_sent < target) send_random_token();
    endtask

    // one illegal case per run, since the error state holds until reset
    task automatic inject_error();
        case ($urandom_range(0, 5))
            0: put_byte($urandom_range(0, 1) ? 8'(8'h80 + $urandom_range(0, 127))
                                             : pick_char("!#&'.\\^_`|~"));
            1: send_text("12a");
            2: send_text("ab\"");
            3: send_text(":x");
            4: send_text("$q:;");
            default: begin
                send_text("k+");
                put_byte(8'h7F);
            end
        endcase
        // ignored until reset
        send_text("12 ab;+");
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every token kind, held colon and equals, string with 00 and ff
        send_text("42+$v:=k=\"");
        put_byte(8'h00);
        put_byte(8'hFF);
        send_text("\";\n:=(b)9 @x;?y\t%<>-*/");

        // string of arbitrary bytes
        put_byte(CH_QUOTE);
        repeat (24) put_byte(rand_string_byte());
        put_byte(CH_QUOTE);
        send_text("; ");

        // random streams; the first phase carries the long hold-off
        hold_go <= 1'b1;
        run_phase(0, 0, 300);
        run_phase(75, 0, 230);
        run_phase(0, 75, 230);
        run_phase(34, 34, 230);
        run_phase(0, 0, 40);

        // run of newlines
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        repeat (20) put_byte(CH_NEWLINE);
        send_text("k;7 $z:=\"s\"\n=");

        inject_error();
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
